### sv/bos_pkg.sv
// Package: operation codes and sequencer states for the bounded ordered sequence.
`timescale 1ns / 1ps
package bos_pkg;

  typedef enum logic [2:0] {
    OP_INSERT_AT  = 3'd0,
    OP_INSERT_ORD = 3'd1,
    OP_ERASE_AT   = 3'd2,
    OP_REMOVE_ALL = 3'd3,
    OP_GET        = 3'd4,
    OP_SET        = 3'd5,
    OP_FIND       = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SHUP,
    ST_SHDN,
    ST_GET,
    ST_DONE
  } state_t;

endpackage

### sv/bos_ram.sv
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module bos_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/bounded_ordered_sequence.sv
// Top level: fixed-capacity list of signed values with positional and ordered operations.
//
// A word is accepted when start is high and busy is low; busy stays high until its
// result has been shown. The result appears for exactly one cycle with out_valid high
// and must be taken then: the receiver cannot stall. All entries live in one
// single-port-read, single-port-write memory, and one entry is read per cycle, so the
// time per word follows the entries walked: get and set touch one entry, find and
// remove_all walk the list from its start, erase_at and insert_at shift the entries at
// or above the position, and insert_ordered searches, then shifts. No clearing pass
// after reset: entries at or above the count are never read.
`timescale 1ns / 1ps
module bounded_ordered_sequence
  import bos_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_operation,
  input  logic [8:0]         in_position,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  output logic               out_success,
  output logic [7:0]         out_result_index,
  output logic [8:0]         out_removed_count,
  output logic signed [31:0] out_read_value,
  output logic [8:0]         out_entry_count,
  output logic               out_is_empty
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic signed [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           i_r, i_nxt;
  logic [CW-1:0]           p_r, p_nxt;
  logic [CW-1:0]           w_r, w_nxt;
  logic [CW-1:0]           rem_r, rem_nxt;
  logic                    rdv_r, rdv_nxt;
  logic [AW-1:0]           rdi_r, rdi_nxt;
  logic                    ok_r, ok_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [31:0]             rdval_r, rdval_nxt;

  logic                    wr_en, rd_en;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic [VALUE_WIDTH-1:0]  wr_data;
  logic signed [VALUE_WIDTH-1:0] rd_data;
  logic signed [VALUE_WIDTH-1:0] in_val;
  logic                    pos_lt, pos_le, full, hit;

  assign in_val = VALUE_WIDTH'(in_item_value);
  assign pos_lt = 32'(in_position) <  32'(cnt_r);
  assign pos_le = 32'(in_position) <= 32'(cnt_r);
  assign full   = cnt_r >= CW'(CAPACITY);

  bos_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rdv_r   <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    val_r   <= val_nxt;
    i_r     <= i_nxt;
    p_r     <= p_nxt;
    w_r     <= w_nxt;
    rem_r   <= rem_nxt;
    rdi_r   <= rdi_nxt;
    ok_r    <= ok_nxt;
    idx_r   <= idx_nxt;
    rdval_r <= rdval_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    p_nxt     = p_r;
    w_nxt     = w_r;
    rem_nxt   = rem_r;
    rdv_nxt   = 1'b0;
    rdi_nxt   = rdi_r;
    ok_nxt    = ok_r;
    idx_nxt   = idx_r;
    rdval_nxt = rdval_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    hit       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = op_t'(in_operation);
          val_nxt   = in_val;
          ok_nxt    = 1'b0;
          idx_nxt   = '0;
          rem_nxt   = '0;
          rdval_nxt = '0;
          state_nxt = ST_DONE;
          case (in_operation)
            OP_INSERT_AT: begin
              if (pos_le && !full) begin
                p_nxt     = CW'(in_position);
                i_nxt     = cnt_r;
                state_nxt = ST_SHUP;
              end
            end
            OP_INSERT_ORD: begin
              if (!full) begin
                i_nxt     = '0;
                state_nxt = ST_SRCH;
              end
            end
            OP_ERASE_AT: begin
              if (pos_lt) begin
                i_nxt     = CW'(in_position) + CW'(1);
                state_nxt = ST_SHDN;
              end
            end
            OP_REMOVE_ALL: begin
              i_nxt     = '0;
              w_nxt     = '0;
              state_nxt = ST_SRCH;
            end
            OP_GET: begin
              if (pos_lt) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_position);
                state_nxt = ST_GET;
              end
            end
            OP_SET: begin
              if (pos_lt) begin
                wr_en   = 1'b1;
                wr_addr = AW'(in_position);
                wr_data = in_val;
                ok_nxt  = 1'b1;
              end
            end
            OP_FIND: begin
              i_nxt     = '0;
              state_nxt = ST_SRCH;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SRCH: begin
        if (rdv_r) begin
          case (op_r)
            OP_INSERT_ORD: hit = rd_data >= val_r;
            OP_FIND:       hit = rd_data == val_r;
            OP_REMOVE_ALL: begin
              if (rd_data == val_r) begin
                rem_nxt = rem_r + CW'(1);
              end else begin
                wr_en   = 1'b1;
                wr_addr = w_r[AW-1:0];
                wr_data = rd_data;
                w_nxt   = w_r + CW'(1);
              end
            end
            default: hit = 1'b0;
          endcase
        end
        if (hit) begin
          if (op_r == OP_INSERT_ORD) begin
            p_nxt     = CW'(rdi_r);
            i_nxt     = cnt_r;
            state_nxt = ST_SHUP;
          end else begin
            ok_nxt    = 1'b1;
            idx_nxt   = CW'(rdi_r);
            state_nxt = ST_DONE;
          end
        end else if (i_r < cnt_r) begin
          rd_en   = 1'b1;
          rd_addr = i_r[AW-1:0];
          rdv_nxt = 1'b1;
          rdi_nxt = i_r[AW-1:0];
          i_nxt   = i_r + CW'(1);
        end else if (!rdv_r) begin
          case (op_r)
            OP_INSERT_ORD: begin
              p_nxt     = cnt_r;
              i_nxt     = cnt_r;
              state_nxt = ST_SHUP;
            end
            OP_REMOVE_ALL: begin
              cnt_nxt   = w_r;
              ok_nxt    = 1'b1;
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SHUP: begin
        if (rdv_r) begin
          wr_en   = 1'b1;
          wr_addr = rdi_r + AW'(1);
          wr_data = rd_data;
        end
        if (i_r > p_r) begin
          rd_en   = 1'b1;
          rd_addr = AW'(i_r - CW'(1));
          rdv_nxt = 1'b1;
          rdi_nxt = AW'(i_r - CW'(1));
          i_nxt   = i_r - CW'(1);
        end else if (!rdv_r) begin
          wr_en     = 1'b1;
          wr_addr   = p_r[AW-1:0];
          wr_data   = val_r;
          cnt_nxt   = cnt_r + CW'(1);
          ok_nxt    = 1'b1;
          idx_nxt   = p_r;
          state_nxt = ST_DONE;
        end
      end

      ST_SHDN: begin
        if (rdv_r) begin
          wr_en   = 1'b1;
          wr_addr = rdi_r - AW'(1);
          wr_data = rd_data;
        end
        if (i_r < cnt_r) begin
          rd_en   = 1'b1;
          rd_addr = i_r[AW-1:0];
          rdv_nxt = 1'b1;
          rdi_nxt = i_r[AW-1:0];
          i_nxt   = i_r + CW'(1);
        end else if (!rdv_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          ok_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end
      end

      ST_GET: begin
        ok_nxt    = 1'b1;
        rdval_nxt = 32'(rd_data);
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy              = state_r != ST_IDLE;
  assign out_valid         = state_r == ST_DONE;
  assign out_success       = ok_r;
  assign out_result_index  = 8'(idx_r);
  assign out_removed_count = 9'(rem_r);
  assign out_read_value    = rdval_r;
  assign out_entry_count   = 9'(cnt_r);
  assign out_is_empty      = cnt_r == '0;

endmodule

### sim/bos_checker.sv
// Checker: list predictor and result scoreboard for the bounded ordered sequence.
`timescale 1ns / 1ps
module bos_checker
  import bos_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         in_operation,
  input  logic [8:0]         in_position,
  input  logic signed [31:0] in_item_value,
  input  logic               out_valid,
  input  logic               out_success,
  input  logic [7:0]         out_result_index,
  input  logic [8:0]         out_removed_count,
  input  logic signed [31:0] out_read_value,
  input  logic [8:0]         out_entry_count,
  input  logic               out_is_empty,
  output int                 mismatch_count,
  output int                 results_due,
  output int                 predicted_count
);

  localparam int DEPTH = 256;
  localparam int IW    = $clog2(DEPTH);

  typedef struct packed {
    logic               success;
    logic [7:0]         index;
    logic [8:0]         removed;
    logic signed [31:0] read_value;
    logic [8:0]         count;
    logic               empty;
  } list_result_t;

  logic signed [31:0] list_mem [DEPTH];
  int unsigned        list_len = 0;
  list_result_t       due_q[$];
  list_result_t       observed;
  list_result_t       predicted;
  int                 errors = 0;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: word mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    errors++;
  endtask

  function automatic bit place_entry(input int unsigned p, input logic signed [31:0] v);
    if (p > list_len || list_len >= DEPTH) return 1'b0;
    for (int unsigned i = list_len; i > p; i--) list_mem[IW'(i)] = list_mem[IW'(i - 1)];
    list_mem[IW'(p)] = v;
    list_len++;
    return 1'b1;
  endfunction

  function automatic list_result_t apply_request(input logic [2:0] op, input logic [8:0] pos,
                                                 input logic signed [31:0] v);
    list_result_t r;
    int unsigned  slot;
    int unsigned  kept;
    int unsigned  p_idx;
    bit           hit;
    r = '0;
    hit = 1'b0;
    p_idx = 32'(pos);
    case (op)
      OP_INSERT_AT: begin
        if (place_entry(p_idx, v)) begin
          r.success = 1'b1;
          r.index   = pos[7:0];
        end
      end
      OP_INSERT_ORD: begin
        slot = list_len;
        for (int unsigned i = 0; i < list_len && !hit; i++) begin
          if (list_mem[IW'(i)] >= v) begin
            slot = i;
            hit  = 1'b1;
          end
        end
        if (place_entry(slot, v)) begin
          r.success = 1'b1;
          r.index   = slot[7:0];
        end
      end
      OP_ERASE_AT: begin
        if (p_idx < list_len) begin
          for (int unsigned i = p_idx; i + 1 < list_len; i++)
            list_mem[IW'(i)] = list_mem[IW'(i + 1)];
          list_len--;
          r.success = 1'b1;
        end
      end
      OP_REMOVE_ALL: begin
        kept = 0;
        for (int unsigned i = 0; i < list_len; i++) begin
          if (list_mem[IW'(i)] == v) begin
            r.removed = r.removed + 9'd1;
          end else begin
            list_mem[IW'(kept)] = list_mem[IW'(i)];
            kept++;
          end
        end
        list_len  = kept;
        r.success = 1'b1;
      end
      OP_GET: begin
        if (p_idx < list_len) begin
          r.success    = 1'b1;
          r.read_value = list_mem[IW'(p_idx)];
        end
      end
      OP_SET: begin
        if (p_idx < list_len) begin
          list_mem[IW'(p_idx)] = v;
          r.success            = 1'b1;
        end
      end
      OP_FIND: begin
        for (int unsigned i = 0; i < list_len && !hit; i++) begin
          if (list_mem[IW'(i)] == v) begin
            r.success = 1'b1;
            r.index   = i[7:0];
            hit       = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.count = list_len[8:0];
    r.empty = (list_len == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = 0;
      due_q.delete();
    end else begin
      if (out_valid) begin
        observed = '{out_success, out_result_index, out_removed_count, out_read_value,
                     out_entry_count, out_is_empty};
        if (due_q.size() == 0) begin
          report_mismatch("unexpected word", 32'(observed.count), 32'd0);
        end else begin
          predicted = due_q.pop_front();
          if (observed.success !== predicted.success)
            report_mismatch("success", 32'(observed.success), 32'(predicted.success));
          if (observed.index !== predicted.index)
            report_mismatch("result_index", 32'(observed.index), 32'(predicted.index));
          if (observed.removed !== predicted.removed)
            report_mismatch("removed_count", 32'(observed.removed), 32'(predicted.removed));
          if (observed.read_value !== predicted.read_value)
            report_mismatch("read_value", observed.read_value, predicted.read_value);
          if (observed.count !== predicted.count)
            report_mismatch("entry_count", 32'(observed.count), 32'(predicted.count));
          if (observed.empty !== predicted.empty)
            report_mismatch("is_empty", 32'(observed.empty), 32'(predicted.empty));
        end
      end
      if (start && !busy) due_q.push_back(apply_request(in_operation, in_position, in_item_value));
    end
    results_due     <= due_q.size();
    predicted_count <= list_len;
    mismatch_count  <= errors;
  end

endmodule

### sim/tb.sv
// Testbench top: stimulus and verdict for the bounded ordered sequence.
`timescale 1ns / 1ps
module tb
  import bos_pkg::*;
();

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int         DEPTH     = 256;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_operation = '0;
  logic [8:0]         in_position = '0;
  logic signed [31:0] in_item_value = '0;
  logic               out_valid;
  logic               out_success;
  logic [7:0]         out_result_index;
  logic [8:0]         out_removed_count;
  logic signed [31:0] out_read_value;
  logic [8:0]         out_entry_count;
  logic               out_is_empty;
  int                 mismatch_count;
  int                 results_due;
  int                 predicted_count;
  int                 idle_pct = 28;
  int                 words_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_ordered_sequence u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_success      (out_success),
    .out_result_index (out_result_index),
    .out_removed_count(out_removed_count),
    .out_read_value   (out_read_value),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty)
  );

  bos_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_success      (out_success),
    .out_result_index (out_result_index),
    .out_removed_count(out_removed_count),
    .out_read_value   (out_read_value),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .mismatch_count   (mismatch_count),
    .results_due      (results_due),
    .predicted_count  (predicted_count)
  );

  task automatic send_word(input logic [2:0] op, input logic [8:0] pos,
                           input logic signed [31:0] val);
    if (idle_pct != 0 && $urandom_range(0, 19) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 300)) @(posedge clk);
    end
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_operation  <= op;
    in_position   <= pos;
    in_item_value <= val;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return int'($urandom_range(0, 6)) - 3;
    if (r < 60) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [8:0] pick_pos(input int n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 9'($urandom_range(0, n));
    if (r < 80) return 9'(n + 1);
    if (r < 85) return (n == 0) ? 9'd0 : 9'(n - 1);
    return 9'($urandom_range(0, 511));
  endfunction

  task automatic random_word(input int len_cap);
    int unsigned r;
    logic [2:0]  op;
    int          n;
    n = predicted_count;
    r = $urandom_range(0, 99);
    if (r < 18)      op = OP_INSERT_AT;
    else if (r < 36) op = OP_INSERT_ORD;
    else if (r < 48) op = OP_ERASE_AT;
    else if (r < 56) op = OP_REMOVE_ALL;
    else if (r < 70) op = OP_GET;
    else if (r < 80) op = OP_SET;
    else if (r < 96) op = OP_FIND;
    else             op = OP_UNUSED;
    if (n >= len_cap && (op == OP_INSERT_AT || op == OP_INSERT_ORD)) op = OP_ERASE_AT;
    send_word(op, pick_pos(n), pick_value());
  endtask

  // fill to capacity, probe the full list, then empty it again (or drain it to eight entries)
  task automatic fill_and_drain(input bit one_value);
    logic signed [31:0] v;
    v = pick_value();
    while (predicted_count < DEPTH) begin
      if (one_value)
        send_word(OP_INSERT_AT, 9'($urandom_range(0, predicted_count)), v);
      else if ($urandom_range(0, 1) == 1)
        send_word(OP_INSERT_ORD, 9'($urandom_range(0, 511)), pick_value());
      else
        send_word(OP_INSERT_AT, 9'($urandom_range(0, predicted_count)), pick_value());
    end
    send_word(OP_INSERT_ORD, 9'd0, v);
    send_word(OP_INSERT_AT, 9'd256, v);
    send_word(OP_SET, 9'd255, ~v);
    send_word(OP_FIND, 9'd0, ~v);
    send_word(OP_GET, 9'd255, 32'sd0);
    send_word(OP_GET, 9'd256, 32'sd0);
    send_word(OP_SET, 9'd256, v);
    send_word(OP_ERASE_AT, 9'd256, v);
    if (one_value) begin
      send_word(OP_SET, 9'd255, v);
      send_word(OP_REMOVE_ALL, 9'd0, v);
    end else begin
      while (predicted_count > 8) begin
        if ($urandom_range(0, 99) < 90)
          send_word(OP_ERASE_AT, 9'($urandom_range(0, predicted_count - 1)), pick_value());
        else
          send_word(OP_REMOVE_ALL, 9'($urandom_range(0, 511)), pick_value());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty list
    send_word(OP_GET, 9'd0, 32'sd0);
    send_word(OP_ERASE_AT, 9'd0, 32'sd0);
    send_word(OP_SET, 9'd0, 32'sd5);
    send_word(OP_FIND, 9'd0, 32'sd0);
    send_word(OP_REMOVE_ALL, 9'd0, 32'sd7);
    send_word(OP_UNUSED, 9'h1ff, -32'sd1);
    send_word(OP_INSERT_AT, 9'd1, 32'sd3);
    // build [min, 0, 0, max, -1]
    send_word(OP_INSERT_AT, 9'd0, 32'sh8000_0000);
    send_word(OP_INSERT_ORD, 9'd0, 32'sh7fff_ffff);
    send_word(OP_INSERT_ORD, 9'd0, 32'sd0);
    send_word(OP_INSERT_ORD, 9'h155, 32'sd0);
    send_word(OP_INSERT_AT, 9'd5, 32'sd1);
    send_word(OP_INSERT_AT, 9'd4, -32'sd1);
    send_word(OP_INSERT_AT, 9'h1ff, 32'sd9);
    send_word(OP_GET, 9'd0, 32'sd0);
    send_word(OP_GET, 9'd4, 32'sd0);
    send_word(OP_GET, 9'd5, 32'sd0);
    send_word(OP_SET, 9'd3, -32'sd1);
    send_word(OP_FIND, 9'd0, -32'sd1);
    send_word(OP_FIND, 9'd0, 32'sd12345);
    // adjacent duplicates
    send_word(OP_REMOVE_ALL, 9'd0, 32'sd0);
    send_word(OP_REMOVE_ALL, 9'd0, -32'sd1);
    send_word(OP_ERASE_AT, 9'd1, 32'sd0);
    send_word(OP_ERASE_AT, 9'd0, 32'sd0);
    send_word(OP_GET, 9'h1ff, 32'sd0);

    fill_and_drain(1'b1);
    while (words_sent < 700) random_word(24);
    wait_all_results();
    idle_pct = 0;
    while (words_sent < 900) random_word(48);
    idle_pct = 28;
    fill_and_drain(1'b0);
    while (words_sent < 1725) random_word(24);

    wait_all_results();
    repeat (600) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("bounded_ordered_sequence verification clean");
    end else begin
      $display("bounded_ordered_sequence verification failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("bounded_ordered_sequence verification failed");
    $finish;
  end

endmodule

### bounded_ordered_sequence.f
sv/bos_pkg.sv
sv/bos_ram.sv
sv/bounded_ordered_sequence.sv
sim/bos_checker.sv
sim/tb.sv
